// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge while reset is released.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("%m: check failed");

// Antecedent implies the consequent at the same edge.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) ((ante) |-> (cons))) \
		else $error("%m: implication failed");

`endif

// ===== rtl/core/srs_pkg.sv =====
// Shared types and constants for the SPI register access slave.
package srs_pkg;

	localparam int DefBufferBytes = 12;
	localparam int NumRegs        = 2;
	localparam int IdxBits        = 4;

	typedef enum logic [1:0] {
		KIND_START = 2'd0,
		KIND_END   = 2'd1,
		KIND_BYTE  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_CMD    = 3'd1,
		PH_RD_ARM = 3'd2,
		PH_RD     = 3'd3,
		PH_WR_ARM = 3'd4,
		PH_WR     = 3'd5
	} phase_t;

	localparam logic [2:0] RC_OK      = 3'd0;
	localparam logic [2:0] RC_ABORTED = 3'd1;
	localparam logic [2:0] RC_BADREG  = 3'd2;
	localparam logic [2:0] RC_BADOP   = 3'd3;
	localparam logic [2:0] RC_BADLEN  = 3'd4;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data_byte;
	} evt_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic [2:0] status_code;
	} res_t;

	typedef struct packed {
		logic hit;
		res_t word;
	} srs_result_t;

endpackage

// ===== rtl/core/srs_core.sv =====
// Protocol state, register buffer and per-event decode of the register access slave.
module srs_core import srs_pkg::*; #(
	parameter int BUFFER_BYTES = DefBufferBytes
) (
	input  logic        clk,
	input  logic        arst_n,
	input  evt_t        evt,
	input  logic        step,
	output srs_result_t result
);

	localparam int AddrW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
	localparam logic [IdxBits-1:0] BufLen = IdxBits'(BUFFER_BYTES);

	phase_t              phase_q, phase_d;
	logic                sel_q, sel_d;
	logic [IdxBits-1:0]  idx_q, idx_d;
	logic [2:0]          rc_q, rc_d;
	logic [7:0]          buf_q [BUFFER_BYTES];

	logic [IdxBits-1:0]  len;
	logic [6:0]          reg_num;
	logic                wr_flag;
	logic                wr_en;
	logic                in_buf;
	logic [7:0]          rd_byte;

	assign len     = sel_q ? BufLen : IdxBits'(1);
	assign reg_num = evt.data_byte[6:0];
	assign wr_flag = evt.data_byte[7];
	assign in_buf  = (idx_q < BufLen);
	assign rd_byte = !sel_q ? {5'b0, rc_q} : (in_buf ? buf_q[idx_q[AddrW-1:0]] : 8'h00);

	always_comb begin
		phase_d = phase_q;
		sel_d   = sel_q;
		idx_d   = idx_q;
		rc_d    = rc_q;
		wr_en   = 1'b0;
		result  = '0;
		case (evt.kind)
			KIND_START: begin
				phase_d = PH_CMD;
				idx_d   = '0;
				rc_d    = RC_OK;
			end
			KIND_END: begin
				if (phase_q != PH_IDLE) begin
					rc_d = RC_ABORTED;
				end
				phase_d = PH_IDLE;
			end
			KIND_BYTE: begin
				case (phase_q)
					PH_CMD: begin
						rc_d = RC_OK;
						if (reg_num >= 7'(NumRegs)) begin
							rc_d    = RC_BADREG;
							sel_d   = 1'b0;
							phase_d = PH_IDLE;
						end else begin
							sel_d = reg_num[0];
							if (reg_num == 7'd0 && wr_flag) begin
								rc_d    = RC_BADOP;
								phase_d = PH_IDLE;
							end else begin
								phase_d = wr_flag ? PH_WR_ARM : PH_RD_ARM;
							end
						end
						result.hit              = 1'b1;
						result.word.tx_byte     = {5'b0, rc_d};
						result.word.status_code = rc_d;
					end
					PH_WR_ARM, PH_WR: begin
						phase_d = PH_WR;
						wr_en   = (idx_q < len) && sel_q && in_buf;
						if (idx_q == len - IdxBits'(1)) begin
							phase_d = PH_IDLE;
						end
						idx_d = idx_q + IdxBits'(1);
					end
					PH_RD_ARM, PH_RD: begin
						phase_d = PH_RD;
						if (idx_q < len) begin
							result.hit              = 1'b1;
							result.word.tx_byte     = rd_byte;
							result.word.status_code = rc_q;
						end
						if (idx_q == len) begin
							phase_d = PH_IDLE;
						end
						idx_d = idx_q + IdxBits'(1);
					end
					default: begin
						// A byte outside any frame counts as a length error once.
						if (rc_q == RC_OK) begin
							rc_d = RC_BADLEN;
						end
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			sel_q   <= 1'b0;
			idx_q   <= '0;
			rc_q    <= RC_OK;
		end else if (step) begin
			phase_q <= phase_d;
			sel_q   <= sel_d;
			idx_q   <= idx_d;
			rc_q    <= rc_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BUFFER_BYTES; i++) begin
				buf_q[i] <= 8'h00;
			end
		end else if (step && wr_en) begin
			buf_q[idx_q[AddrW-1:0]] <= evt.data_byte;
		end
	end

endmodule

// ===== rtl/core/spi_register_access_slave.sv =====
// Top level of the SPI register access slave: input register, protocol core, result register.
// The block follows the register protocol of an SPI slave, one event word at a time: frame
// start, frame end, or a byte received from the master. The first byte after a frame start
// is a command (register number in bits 6:0, write flag in bit 7); it answers with one result
// word carrying the status code. Bytes of a read frame answer with the next register byte
// while any is left, and one byte past the end closes the read without an answer; bytes
// of a write frame are stored and answer nothing. Register 0 is the read-only status byte,
// register 1 a BUFFER_BYTES byte buffer that reset clears. An accepted event is held in the
// input register and decoded against the protocol state there; its result word (if any)
// goes to the result register and res. One event is taken every cycle; the only stall is in
// the result register, when it holds an untaken word and the input event would yield another.
module spi_register_access_slave import srs_pkg::*; #(
	parameter int BUFFER_BYTES = DefBufferBytes
) (
	input  logic clk,
	input  logic arst_n,
	input  logic evt_valid,
	output logic evt_ready,
	input  evt_t evt,
	output logic res_valid,
	input  logic res_ready,
	output res_t res
);

	// Input register holding the event under decode.
	logic        valid_s1;
	evt_t        evt_s1;

	// Result register toward the consumer.
	logic        res_valid_q;
	res_t        res_q;

	srs_result_t result;
	logic        advance;

	// The event leaves the input register unless it has a word to deliver and the result
	// register is still occupied.
	assign advance   = valid_s1 && (!result.hit || !res_valid_q || res_ready);
	assign evt_ready = !valid_s1 || advance;

	srs_core #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt_s1),
		.step   (advance),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt_valid && evt_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (evt_valid && evt_ready) begin
			evt_s1 <= evt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && result.hit) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && result.hit) begin
			res_q <= result.word;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ===== rtl/core/srs_checker.sv =====
// Port-level checks for the SPI register access slave, bound to its top level.
`include "assert_macros.svh"

module srs_checker import srs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic evt_ready,
	input logic res_valid,
	input logic res_ready,
	input res_t res
);

	// A result word waits until it is taken.
	`ASSERT_CLK(a_res_hold, clk, arst_n, res_valid && !res_ready |=> res_valid)

	// A waiting result word keeps its value.
	`ASSERT_CLK(a_res_stable, clk, arst_n, res_valid && !res_ready |=> $stable(res))

	// Intake only stops behind a result word that is still waiting.
	`ASSERT_IMPLY(a_stall_cause, clk, arst_n, !evt_ready, res_valid && !res_ready)

	// Status codes stay within the defined set.
	`ASSERT_IMPLY(a_status_range, clk, arst_n, res_valid, res.status_code <= RC_BADLEN)

endmodule

bind spi_register_access_slave srs_checker u_srs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.evt_ready (evt_ready),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res       (res)
);

// ===== tb/spi_register_access_slave_tb.sv =====
// Self-checking testbench for the SPI register access slave, with its own protocol predictor.
`timescale 1ns / 100ps

module spi_register_access_slave_tb;
	import srs_pkg::*;

	// The unused event code must pass through without effect.
	localparam logic [1:0] KindUnused = 2'd3;
	// Register numbers as they appear in bits 6:0 of a command byte.
	localparam logic [6:0] RegStatus = 7'd0;
	localparam logic [6:0] RegBuffer = 7'd1;
	localparam int BufBytes = DefBufferBytes;
	localparam int RandomEvents = 400;

	// One row of the directed table. A pinned row carries the reply word that is
	// obvious by inspection; all other rows are checked against the predictor.
	typedef struct packed {
		evt_t ev;
		bit   pinned;
		res_t want;
	} probe_row_t;

	logic clk;
	logic arst_n;
	logic evt_valid;
	logic evt_ready;
	evt_t evt;
	logic res_valid;
	logic res_ready;
	res_t res;

	spi_register_access_slave DUT (
		.clk(clk),
		.arst_n(arst_n),
		.evt_valid(evt_valid),
		.evt_ready(evt_ready),
		.evt(evt),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

	// Predictor state: the protocol phase, the register picked by the last
	// command, the byte position within the frame, the current status code and
	// the contents of the read-write buffer.
	phase_t     model_phase;
	logic       model_sel;
	logic [3:0] model_idx;
	logic [2:0] model_rc;
	logic [7:0] model_mem [BufBytes];

	// Reply words still owed by the block, oldest first.
	res_t expected_replies [$];

	// Pinned expectation travelling with the word currently on the input.
	bit   pin_active;
	res_t pin_word;

	// When set, neither side idles; this gives back-to-back stretches.
	bit quiet_stretch;
	int unsigned reply_hold;

	int mismatch_count;
	int replies_checked;
	int items_sent;
	int frames_run;
	int read_frames;
	int write_frames;
	int rejected_cmds;

	probe_row_t probe_rows [$];

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// A run that hangs anywhere ends here as a failure.
	initial begin
		#3ms;
		$display("%0t: timeout, %0d reply words still owed", $time, expected_replies.size());
		$display("Some tests failed");
		$finish;
	end

	// Advance the predictor by one accepted event word. Returns 1 when the event
	// produces a reply word, which is then left in reply.
	function automatic bit predict_spi_event(input evt_t ev, output res_t reply);
		logic [6:0] regno;
		int span;
		bit hit;
		hit = 1'b0;
		reply = '0;
		span = model_sel ? BufBytes : 1;
		case (ev.kind)
			KIND_START: begin
				model_phase = PH_CMD;
				model_idx = '0;
				model_rc = RC_OK;
			end
			KIND_END: begin
				// Ending a frame anywhere but idle counts as an aborted transfer.
				if (model_phase != PH_IDLE)
					model_rc = RC_ABORTED;
				model_phase = PH_IDLE;
			end
			KIND_BYTE: begin
				case (model_phase)
					PH_CMD: begin
						regno = ev.data_byte[6:0];
						model_rc = RC_OK;
						if (int'(regno) >= NumRegs) begin
							model_rc = RC_BADREG;
							model_sel = 1'b0;
							model_phase = PH_IDLE;
						end else begin
							model_sel = regno[0];
							// The status register cannot be written.
							if (regno == RegStatus && ev.data_byte[7]) begin
								model_rc = RC_BADOP;
								model_phase = PH_IDLE;
							end else begin
								model_phase = ev.data_byte[7] ? PH_WR_ARM : PH_RD_ARM;
							end
						end
						reply.tx_byte = {5'd0, model_rc};
						reply.status_code = model_rc;
						hit = 1'b1;
					end
					PH_WR_ARM, PH_WR: begin
						model_phase = PH_WR;
						if (int'(model_idx) < span && model_sel)
							model_mem[model_idx] = ev.data_byte;
						if (int'(model_idx) == span - 1)
							model_phase = PH_IDLE;
						model_idx = model_idx + 4'd1;
					end
					PH_RD_ARM, PH_RD: begin
						model_phase = PH_RD;
						if (int'(model_idx) < span) begin
							reply.tx_byte = model_sel ? model_mem[model_idx] : {5'd0, model_rc};
							reply.status_code = model_rc;
							hit = 1'b1;
						end
						// One byte past the end closes the read without a reply.
						if (int'(model_idx) == span)
							model_phase = PH_IDLE;
						model_idx = model_idx + 4'd1;
					end
					default: begin
						// A byte outside any frame flags a length error, unless an
						// earlier error is already being reported.
						if (model_rc == RC_OK)
							model_rc = RC_BADLEN;
					end
				endcase
			end
			default: begin
			end
		endcase
		return hit;
	endfunction

	// Both handshakes are sampled here, at the rising edge. Reply words are
	// checked before the event of the same edge is predicted; since the input and result
	// registers lie between an event and its reply, the two can never belong together.
	always @(posedge clk) begin : observe
		res_t predicted;
		res_t want;
		if (arst_n) begin
			if (res_valid && res_ready) begin
				if (expected_replies.size() == 0) begin
					$display("%0t: unexpected reply word: tx_byte %02h status_code %0d",
						$time, res.tx_byte, res.status_code);
					mismatch_count++;
				end else begin
					want = expected_replies.pop_front();
					if (res.tx_byte !== want.tx_byte) begin
						$display("%0t: tx_byte mismatch: expected %02h, actual %02h",
							$time, want.tx_byte, res.tx_byte);
						mismatch_count++;
					end
					if (res.status_code !== want.status_code) begin
						$display("%0t: status_code mismatch: expected %0d, actual %0d",
							$time, want.status_code, res.status_code);
						mismatch_count++;
					end
					replies_checked++;
				end
				reply_hold = quiet_stretch ? 0 : $urandom_range(0, 18);
			end
			if (evt_valid && evt_ready) begin
				if (predict_spi_event(evt, predicted))
					expected_replies.push_back(pin_active ? pin_word : predicted);
			end
		end
	end

	// The receiver stalls for the drawn number of cycles after each reply word.
	always @(negedge clk) begin
		if (reply_hold != 0) begin
			res_ready <= 1'b0;
			reply_hold = reply_hold - 1;
		end else begin
			res_ready <= 1'b1;
		end
	end

	// Offer one event word after a random gap and wait until it is taken. Valid
	// stays high past acceptance; the next call either replaces the word at the
	// following falling edge or drops valid for the gap.
	task automatic send_event(input evt_t ev, input bit pinned, input res_t want);
		int unsigned gap;
		gap = quiet_stretch ? 0 : $urandom_range(0, 18);
		@(negedge clk);
		if (gap != 0) begin
			evt_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		evt <= ev;
		pin_active <= pinned;
		pin_word <= want;
		evt_valid <= 1'b1;
		do @(posedge clk); while (!(evt_valid && evt_ready));
		if (ev.kind != KindUnused)
			items_sent++;
	endtask

	// Hold off the sender until every owed reply word has been seen or the limit runs out,
	// then keep watching the pipeline for anything it should not show.
	task automatic wait_for_replies(input int limit);
		int waited;
		waited = 0;
		@(negedge clk);
		evt_valid <= 1'b0;
		while (expected_replies.size() != 0 && waited < limit) begin
			@(posedge clk);
			waited++;
		end
		repeat (4) @(posedge clk);
	endtask

	function automatic probe_row_t plain_row(input logic [1:0] kind, input logic [7:0] data);
		plain_row = '{ev: '{kind: kind, data_byte: data}, pinned: 1'b0, want: '0};
	endfunction

	function automatic probe_row_t pinned_row(input logic [1:0] kind, input logic [7:0] data,
			input logic [7:0] tx, input logic [2:0] code);
		pinned_row = '{ev: '{kind: kind, data_byte: data}, pinned: 1'b1,
			want: '{tx_byte: tx, status_code: code}};
	endfunction

	// One random frame: mostly a well-formed command followed by data bytes,
	// sometimes cut short, overlong or left without a frame end, and now and
	// then a burst of arbitrary events.
	task automatic run_random_frame();
		logic [6:0] regno;
		bit wr;
		int span;
		int nbytes;
		int pick;
		evt_t ev;
		quiet_stretch = ($urandom_range(0, 3) == 0);
		frames_run++;
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 4)) begin
				ev.kind = 2'($urandom_range(0, 3));
				ev.data_byte = 8'($urandom);
				send_event(ev, 1'b0, '0);
			end
		end else begin
			send_event('{kind: KIND_START, data_byte: 8'($urandom)}, 1'b0, '0);
			pick = $urandom_range(0, 9);
			if (pick < 4)
				regno = RegStatus;
			else if (pick < 9)
				regno = RegBuffer;
			else
				regno = 7'($urandom_range(NumRegs, 127));
			wr = 1'($urandom);
			if (int'(regno) >= NumRegs || (regno == RegStatus && wr))
				rejected_cmds++;
			else if (wr)
				write_frames++;
			else
				read_frames++;
			send_event('{kind: KIND_BYTE, data_byte: {wr, regno}}, 1'b0, '0);
			span = (regno == RegBuffer) ? BufBytes : 1;
			if ($urandom_range(0, 3) == 0)
				nbytes = $urandom_range(0, span + 2);
			else
				nbytes = span + (wr ? 0 : $urandom_range(0, 1));
			repeat (nbytes)
				send_event('{kind: KIND_BYTE, data_byte: 8'($urandom)}, 1'b0, '0);
			if ($urandom_range(0, 4) != 0)
				send_event('{kind: KIND_END, data_byte: 8'($urandom)}, 1'b0, '0);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		evt_valid = 1'b0;
		evt = '0;
		res_ready = 1'b0;
		pin_active = 1'b0;
		pin_word = '0;
		quiet_stretch = 1'b0;
		reply_hold = 0;
		mismatch_count = 0;
		replies_checked = 0;
		items_sent = 0;
		frames_run = 0;
		read_frames = 0;
		write_frames = 0;
		rejected_cmds = 0;

		// The predictor starts from the reset state of the block.
		model_phase = PH_IDLE;
		model_sel = 1'b0;
		model_idx = '0;
		model_rc = RC_OK;
		foreach (model_mem[i])
			model_mem[i] = '0;

		probe_rows = '{
			// A stray byte straight after reset: length error, no reply.
			plain_row(KIND_BYTE, 8'h5A),
			// Read of the status register gives ok twice, then closes quietly; a stray byte then flags a length error.
			plain_row(KIND_START, 8'h00),
			pinned_row(KIND_BYTE, {1'b0, RegStatus}, {5'd0, RC_OK}, RC_OK),
			pinned_row(KIND_BYTE, 8'hFF, {5'd0, RC_OK}, RC_OK),
			plain_row(KIND_BYTE, 8'h00),
			plain_row(KIND_BYTE, 8'hA5),
			// Writing the status register is refused.
			plain_row(KIND_START, 8'hFF),
			pinned_row(KIND_BYTE, {1'b1, RegStatus}, {5'd0, RC_BADOP}, RC_BADOP),
			// Highest register number, and the first one past the end.
			plain_row(KIND_START, 8'h00),
			pinned_row(KIND_BYTE, {1'b0, 7'h7F}, {5'd0, RC_BADREG}, RC_BADREG),
			plain_row(KIND_START, 8'h00),
			pinned_row(KIND_BYTE, {1'b1, 7'(NumRegs)}, {5'd0, RC_BADREG}, RC_BADREG),
			// Partial buffer write with byte extremes, cut off by a frame end.
			plain_row(KIND_START, 8'h00),
			pinned_row(KIND_BYTE, {1'b1, RegBuffer}, {5'd0, RC_OK}, RC_OK),
			plain_row(KIND_BYTE, 8'hFF),
			plain_row(KIND_BYTE, 8'h00),
			plain_row(KIND_END, 8'hFF),
			// Read the same bytes back, then one still at its reset value.
			plain_row(KIND_START, 8'h00),
			pinned_row(KIND_BYTE, {1'b0, RegBuffer}, {5'd0, RC_OK}, RC_OK),
			pinned_row(KIND_BYTE, 8'h00, 8'hFF, RC_OK),
			pinned_row(KIND_BYTE, 8'hFF, 8'h00, RC_OK),
			plain_row(KIND_BYTE, 8'h3C),
			plain_row(KIND_END, 8'h00),
			// The unused event code, then a frame end while already idle.
			plain_row(KindUnused, 8'hFF),
			plain_row(KIND_END, 8'h00)
		};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (probe_rows[i])
			send_event(probe_rows[i].ev, probe_rows[i].pinned, probe_rows[i].want);
		wait_for_replies(20000);

		while (items_sent < probe_rows.size() + RandomEvents) begin
			run_random_frame();
			if (frames_run % 40 == 0)
				wait_for_replies(20000);
		end
		quiet_stretch = 1'b0;

		wait_for_replies(20000);
		repeat (8) @(posedge clk);
		if (expected_replies.size() != 0) begin
			$display("%0t: %0d reply words never arrived", $time, expected_replies.size());
			mismatch_count += expected_replies.size();
		end

		$display("Sent %0d events in %0d random frames: %0d reads, %0d writes, %0d refused commands",
			items_sent, frames_run, read_frames, write_frames, rejected_cmds);
		$display("Checked %0d reply words, %0d mismatches", replies_checked, mismatch_count);
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
